// ----- src/pcpa_pkg.sv -----
// Package for the per-CPU page allocator with stealing.
// Holds sizes, request and status codes, register indexes and the link type.
// No dependencies.
`default_nettype none

package pcpa_pkg;

	localparam int NUM_CPUS  = 8;
	localparam int CPU_W     = 3;
	localparam int NUM_PAGES = 4096;
	localparam int PAGE_W    = $clog2(NUM_PAGES);
	localparam int LINK_W    = PAGE_W + 1;
	localparam int LEN_W     = 13;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 13;

	localparam logic [LEN_W-1:0] LEN_MAX = '1;

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_NO_MEM   = 2'd1;
	localparam logic [1:0] STATUS_BAD_ADDR = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_PAGE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PAGE_LIMIT = 1'd1;

	typedef struct packed {
		logic              valid;
		logic [PAGE_W-1:0] page;
	} link_t;

endpackage

`default_nettype wire

// ----- src/pcpa_ram.sv -----
// Generic simple dual-port RAM with one write port and one registered read port.
// Stand-alone; used for the page link store of the allocator.
`default_nettype none

module pcpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ----- src/per_cpu_page_allocator_steal_unit.sv -----
// Per-CPU page allocator with work stealing, built on pcpa_pkg and pcpa_ram (page link store).
// A free's result is registered on acceptance, a pop's from the own list in ST_POP.
// A steal scans the CPUs for a victim in ST_SCAN, checks it in ST_CHECK and walks in ST_WALK,
// following at most half the victim's length in links; one link memory read a cycle.
// One request at a time; in_stall is high outside ST_IDLE, left by a free only on out_stall.
// Reset empties all lists and restores the bounds; the link memory is not cleared.
`default_nettype none

module per_cpu_page_allocator_steal_unit
	import pcpa_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic                 req_type,
	input  wire logic [CPU_W-1:0]     requester_cpu,
	input  wire logic [PAGE_W-1:0]    page_index,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic      [1:0]           status,
	output logic      [PAGE_W-1:0]    granted_page
);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_POP   = 6'b000010,
		ST_SCAN  = 6'b000100,
		ST_CHECK = 6'b001000,
		ST_WALK  = 6'b010000,
		ST_FIN   = 6'b100000
	} state_t;

	localparam logic [CPU_W-1:0] CPU_LAST = CPU_W'(NUM_CPUS - 1);

	state_t             state_q;
	link_t              head_q [NUM_CPUS];
	logic [LEN_W-1:0]   len_q [NUM_CPUS];
	logic [PAGE_W-1:0]  first_page_q;
	logic [LEN_W-1:0]   page_limit_q;
	logic [CPU_W-1:0]   cpu_q;
	logic [PAGE_W-1:0]  page_q;
	logic [CPU_W-1:0]   scan_q;
	logic [LEN_W-1:0]   best_q;
	logic [CPU_W-1:0]   victim_q;
	logic               found_q;
	logic [PAGE_W-1:0]  cur_q;
	logic [PAGE_W-1:0]  steps_q;
	link_t              first_q;
	logic [1:0]         res_status_q;
	logic [PAGE_W-1:0]  res_page_q;
	logic               out_valid_q;
	logic [1:0]         out_status_q;
	logic [PAGE_W-1:0]  out_page_q;

	logic               accept;
	logic               out_free;
	logic               out_load;
	link_t              hd;
	link_t              hv;
	link_t              nxt;
	logic [PAGE_W-1:0]  half;
	logic               walk_end;
	logic               cpu_ok;
	logic               free_ok;
	logic               done;
	logic [1:0]         res_status;
	logic [PAGE_W-1:0]  res_page;
	logic               ram_we;
	logic [PAGE_W-1:0]  ram_waddr;
	logic [LINK_W-1:0]  ram_wdata;
	logic [PAGE_W-1:0]  ram_raddr;
	logic [LINK_W-1:0]  ram_rdata;

	pcpa_ram #(
		.WIDTH(LINK_W),
		.DEPTH(NUM_PAGES)
	) u_link_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign in_stall     = (state_q != ST_IDLE);
	assign accept       = in_valid && !in_stall;
	assign out_free     = !out_valid_q || !out_stall;
	assign out_load     = out_free && (done || state_q == ST_FIN);
	assign out_valid    = out_valid_q;
	assign status       = out_status_q;
	assign granted_page = out_page_q;

	assign hd       = head_q[requester_cpu];
	assign hv       = head_q[victim_q];
	assign nxt      = link_t'(ram_rdata);
	assign half     = best_q[LEN_W-1:1];
	assign walk_end = (steps_q == half) || !nxt.valid;
	assign cpu_ok   = ({1'b0, requester_cpu} < (CPU_W+1)'(NUM_CPUS));
	assign free_ok  = cpu_ok && (page_index >= first_page_q)
		&& ({1'b0, page_index} < page_limit_q)
		&& ({1'b0, page_index} < LINK_W'(NUM_PAGES));

	always_comb begin
		ram_we     = 1'b0;
		ram_waddr  = page_index;
		ram_wdata  = hd;
		ram_raddr  = hd.page;
		done       = 1'b0;
		res_status = STATUS_OK;
		res_page   = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (req_type == REQ_FREE) begin
						done = 1'b1;
						if (free_ok) begin
							ram_we = 1'b1;
						end else begin
							res_status = STATUS_BAD_ADDR;
						end
					end else if (!cpu_ok) begin
						done       = 1'b1;
						res_status = STATUS_NO_MEM;
					end
				end
			end
			ST_POP: begin
				done     = 1'b1;
				res_page = page_q;
			end
			ST_CHECK: begin
				ram_raddr = hv.page;
				if (!found_q || !hv.valid) begin
					done       = 1'b1;
					res_status = STATUS_NO_MEM;
				end else if (half == '0) begin
					done     = 1'b1;
					res_page = hv.page;
				end
			end
			ST_WALK: begin
				ram_raddr = nxt.page;
				if (walk_end) begin
					done     = 1'b1;
					res_page = page_q;
					if (steps_q != '0) begin
						ram_we    = 1'b1;
						ram_waddr = cur_q;
						ram_wdata = '0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			first_page_q <= '0;
			page_limit_q <= LEN_W'(NUM_PAGES);
			out_valid_q  <= 1'b0;
			out_status_q <= STATUS_OK;
			out_page_q   <= '0;
			res_status_q <= STATUS_OK;
			res_page_q   <= '0;
			cpu_q        <= '0;
			page_q       <= '0;
			scan_q       <= '0;
			best_q       <= '0;
			victim_q     <= '0;
			found_q      <= 1'b0;
			cur_q        <= '0;
			steps_q      <= '0;
			first_q      <= '0;
			for (int i = 0; i < NUM_CPUS; i++) begin
				head_q[i] <= '0;
				len_q[i]  <= '0;
			end
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_FIRST_PAGE: first_page_q <= cfg_data[PAGE_W-1:0];
					CFG_PAGE_LIMIT: page_limit_q <= cfg_data;
					default: begin
					end
				endcase
			end

			if (out_valid_q && !out_stall && !out_load) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cpu_q <= requester_cpu;
						if (req_type == REQ_FREE) begin
							if (free_ok) begin
								head_q[requester_cpu] <= '{valid: 1'b1, page: page_index};
								if (len_q[requester_cpu] != LEN_MAX) begin
									len_q[requester_cpu] <= len_q[requester_cpu] + 1'b1;
								end
							end
						end else if (cpu_ok) begin
							if (hd.valid) begin
								page_q  <= hd.page;
								state_q <= ST_POP;
							end else begin
								scan_q  <= '0;
								best_q  <= '0;
								victim_q <= '0;
								found_q <= 1'b0;
								state_q <= ST_SCAN;
							end
						end
					end
				end
				ST_POP: begin
					head_q[cpu_q] <= nxt;
					if (len_q[cpu_q] != '0) begin
						len_q[cpu_q] <= len_q[cpu_q] - 1'b1;
					end
				end
				ST_SCAN: begin
					if (scan_q != cpu_q && len_q[scan_q] > best_q) begin
						best_q   <= len_q[scan_q];
						victim_q <= scan_q;
						found_q  <= 1'b1;
					end
					if (scan_q == CPU_LAST) begin
						state_q <= ST_CHECK;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				ST_CHECK: begin
					if (found_q && hv.valid) begin
						if (half == '0) begin
							head_q[victim_q] <= '0;
							len_q[victim_q]  <= '0;
							head_q[cpu_q]    <= '0;
							len_q[cpu_q]     <= '0;
						end else begin
							cur_q   <= hv.page;
							page_q  <= hv.page;
							steps_q <= '0;
							state_q <= ST_WALK;
						end
					end
				end
				ST_WALK: begin
					if (walk_end) begin
						if (steps_q == '0) begin
							head_q[victim_q] <= '0;
							len_q[victim_q]  <= '0;
							head_q[cpu_q]    <= '0;
							len_q[cpu_q]     <= '0;
						end else begin
							head_q[cpu_q]    <= first_q;
							head_q[victim_q] <= nxt;
							len_q[victim_q]  <= best_q - 1'b1 - {1'b0, half};
							len_q[cpu_q]     <= {1'b0, half};
						end
					end else begin
						if (steps_q == '0) begin
							first_q <= nxt;
						end
						cur_q   <= nxt.page;
						steps_q <= steps_q + 1'b1;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_page_q   <= res_page_q;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (done) begin
				res_status_q <= res_status;
				res_page_q   <= res_page;
				if (out_free) begin
					out_valid_q  <= 1'b1;
					out_status_q <= res_status;
					out_page_q   <= res_page;
					state_q      <= ST_IDLE;
				end else begin
					state_q <= ST_FIN;
				end
			end
		end
	end

`ifndef ASSERT_OFF
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("allocator state is not one-hot");

	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != ST_IDLE || out_valid_q))
		else $error("accepted request produced neither work nor a result");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (steps_q <= half))
		else $error("steal walk went past the middle of the victim list");

	a_walk_victim: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (found_q && victim_q != cpu_q))
		else $error("steal walk without a valid victim");
`endif

endmodule

`default_nettype wire
